// ===== rtl/core/depth_pixel_backprojection_defines.svh =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection: assertion macros
// Concurrent check macros shared by the back-projection RTL.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Overlapping implication, checked at every rising edge outside reset.
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Non-overlapping implication, checked at every rising edge outside reset.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection: package
// Beat types, register map and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

	// Field widths.
	localparam int unsigned COORD_W  = 12;
	localparam int unsigned DEPTH_W  = 16;
	localparam int unsigned COLOR_W  = 8;
	localparam int unsigned CENTER_W = 16;
	localparam int unsigned RECIP_W  = 24;
	localparam int unsigned POINT_W  = 32;

	// Configuration port geometry.
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_CENTER_X     = 3'd0;
	localparam logic [2:0] REG_CENTER_Y     = 3'd1;
	localparam logic [2:0] REG_RECIP_FX     = 3'd2;
	localparam logic [2:0] REG_RECIP_FY     = 3'd3;
	localparam logic [2:0] REG_RECIP_DSCALE = 3'd4;

	// Register reset values.
	localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
	localparam logic [RECIP_W-1:0]  RST_RECIP_FX     = 24'd31957;
	localparam logic [RECIP_W-1:0]  RST_RECIP_FY     = 24'd31957;
	localparam logic [RECIP_W-1:0]  RST_RECIP_DSCALE = 24'd16777;

	// Saturation bounds of the lateral coordinates.
	localparam logic [POINT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [POINT_W-1:0] SAT_NEG = 32'h8000_0000;

	// Input beat: one RGB-D pixel.
	typedef struct packed {
		logic [COORD_W-1:0] pixel_row;
		logic [COORD_W-1:0] pixel_col;
		logic [DEPTH_W-1:0] depth_raw;
		logic [COLOR_W-1:0] blue_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] red_in;
	} pixel_t;

	// Result beat: one 3-D point with its colour.
	typedef struct packed {
		logic signed [POINT_W-1:0] point_x;
		logic signed [POINT_W-1:0] point_y;
		logic [POINT_W-1:0]        point_z;
		logic [COLOR_W-1:0]        blue_out;
		logic [COLOR_W-1:0]        green_out;
		logic [COLOR_W-1:0]        red_out;
	} point_t;

	// Colour carried alongside the arithmetic.
	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} color_t;

endpackage

`default_nettype wire

// ===== rtl/core/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Pinhole back-projection of RGB-D pixels to Q16.16 points with colour.
// ----------------------------------------------------------------------------
// The block takes one pixel beat in every clock cycle (busy is never raised)
// and returns its point through the arithmetic pipeline, with done high
// for a single cycle per point; results cannot be held off, so the receiver must
// take every beat as it comes. The stages of the six-stage arithmetic
// pipeline: offset, three parallel 16x24 multiplies, depth rounding, 20x32
// partial products, the 72-bit sum with rounding, and saturation. Pixels off
// the subsampling grid or with zero depth give no result and leave no gap in
// the stream of others. The user must write registers over the APB port
// only while no beat is in flight; the block does not enforce this.
`default_nettype none

module depth_pixel_backprojection #(
	parameter int unsigned SUBSAMPLE_STRIDE = 2
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Pixel command channel.
	input  wire                          start,
	output logic                         busy,
	input  wire  dpb_pkg::pixel_t        pixel,
	// Result channel.
	output logic                         done,
	output dpb_pkg::point_t              point,
	// Configuration port.
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [dpb_pkg::ADDR_W-1:0]   paddr,
	input  wire  [dpb_pkg::DATA_W-1:0]   pwdata,
	output logic [dpb_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	// Divisibility test by multiplication with the rounded-up reciprocal:
	// the low FRAC_W bits of value * STRIDE_M fall below STRIDE_M exactly
	// when the value is a multiple of the stride.
	localparam int unsigned FRAC_W       = 24;
	localparam int unsigned STRIDE_M_W   = FRAC_W + 1;
	localparam int unsigned STRIDE_RECIP =
		((2 ** FRAC_W) + SUBSAMPLE_STRIDE - 1) / SUBSAMPLE_STRIDE;
	localparam logic [STRIDE_M_W-1:0] STRIDE_M = STRIDE_M_W'(STRIDE_RECIP);
	localparam int unsigned GRID_PROD_W = dpb_pkg::COORD_W + STRIDE_M_W;

	localparam int unsigned MAG_W   = dpb_pkg::CENTER_W;
	localparam int unsigned PROD_W  = MAG_W + dpb_pkg::RECIP_W;
	localparam int unsigned HALF_W  = PROD_W / 2;
	localparam int unsigned PART_W  = HALF_W + dpb_pkg::POINT_W;
	localparam int unsigned SUM_W   = PROD_W + dpb_pkg::POINT_W;
	localparam int unsigned Q_SHIFT = 28;
	localparam int unsigned Q_W     = SUM_W - Q_SHIFT;
	localparam int unsigned Z_SHIFT = 8;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [dpb_pkg::CENTER_W-1:0] center_x_q;
	logic [dpb_pkg::CENTER_W-1:0] center_y_q;
	logic [dpb_pkg::RECIP_W-1:0]  recip_fx_q;
	logic [dpb_pkg::RECIP_W-1:0]  recip_fy_q;
	logic [dpb_pkg::RECIP_W-1:0]  recip_dscale_q;
	logic                         cfg_wr;
	logic [2:0]                   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= dpb_pkg::RST_CENTER_X;
			center_y_q     <= dpb_pkg::RST_CENTER_Y;
			recip_fx_q     <= dpb_pkg::RST_RECIP_FX;
			recip_fy_q     <= dpb_pkg::RST_RECIP_FY;
			recip_dscale_q <= dpb_pkg::RST_RECIP_DSCALE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				dpb_pkg::REG_CENTER_X:     center_x_q     <= pwdata[dpb_pkg::CENTER_W-1:0];
				dpb_pkg::REG_CENTER_Y:     center_y_q     <= pwdata[dpb_pkg::CENTER_W-1:0];
				dpb_pkg::REG_RECIP_FX:     recip_fx_q     <= pwdata[dpb_pkg::RECIP_W-1:0];
				dpb_pkg::REG_RECIP_FY:     recip_fy_q     <= pwdata[dpb_pkg::RECIP_W-1:0];
				dpb_pkg::REG_RECIP_DSCALE: recip_dscale_q <= pwdata[dpb_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back of the register file.
	always_comb begin
		case (cfg_idx)
			dpb_pkg::REG_CENTER_X:     prdata = dpb_pkg::DATA_W'(center_x_q);
			dpb_pkg::REG_CENTER_Y:     prdata = dpb_pkg::DATA_W'(center_y_q);
			dpb_pkg::REG_RECIP_FX:     prdata = dpb_pkg::DATA_W'(recip_fx_q);
			dpb_pkg::REG_RECIP_FY:     prdata = dpb_pkg::DATA_W'(recip_fy_q);
			dpb_pkg::REG_RECIP_DSCALE: prdata = dpb_pkg::DATA_W'(recip_dscale_q);
			default:                   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Entry: grid test, depth test and signed offsets from the centre
	// ------------------------------------------------------------------
	logic                      accept;
	logic [GRID_PROD_W-1:0]    row_grid;
	logic [GRID_PROD_W-1:0]    col_grid;
	logic                      keep;
	logic [MAG_W-1:0]          col_p16;
	logic [MAG_W-1:0]          row_p16;
	logic                      neg_x;
	logic                      neg_y;
	logic [MAG_W-1:0]          mag_x;
	logic [MAG_W-1:0]          mag_y;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign row_grid = GRID_PROD_W'(pixel.pixel_row) * GRID_PROD_W'(STRIDE_M);
	assign col_grid = GRID_PROD_W'(pixel.pixel_col) * GRID_PROD_W'(STRIDE_M);
	assign keep = (STRIDE_M_W'(row_grid[FRAC_W-1:0]) < STRIDE_M) &&
		(STRIDE_M_W'(col_grid[FRAC_W-1:0]) < STRIDE_M) &&
		(pixel.depth_raw != '0);

	assign col_p16 = {pixel.pixel_col, 4'd0};
	assign row_p16 = {pixel.pixel_row, 4'd0};
	assign neg_x   = col_p16 < center_x_q;
	assign neg_y   = row_p16 < center_y_q;
	assign mag_x   = neg_x ? (center_x_q - col_p16) : (col_p16 - center_x_q);
	assign mag_y   = neg_y ? (center_y_q - row_p16) : (row_p16 - center_y_q);

	// ------------------------------------------------------------------
	// Pipeline registers
	// ------------------------------------------------------------------
	logic                        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	dpb_pkg::color_t             col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;
	logic                        nx_s1, nx_s2, nx_s3, nx_s4, nx_s5;
	logic                        ny_s1, ny_s2, ny_s3, ny_s4, ny_s5;
	logic [dpb_pkg::DEPTH_W-1:0] depth_s1;
	logic [MAG_W-1:0]            mx_s1, my_s1;
	logic [PROD_W-1:0]           zp_s2, mx_s2, my_s2;
	logic [dpb_pkg::POINT_W-1:0] z_s3, z_s4, z_s5, z_s6;
	logic [PROD_W-1:0]           mx_s3, my_s3;
	logic [PART_W-1:0]           xh_s4, xl_s4, yh_s4, yl_s4;
	logic [Q_W-1:0]              qx_s5, qy_s5;
	logic [dpb_pkg::POINT_W-1:0] px_s6, py_s6;

	// Valid bits travel with the beat; skipped pixels never enter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept && keep;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: capture offsets, signs, depth and colour.
	always_ff @(posedge clk) begin
		depth_s1     <= pixel.depth_raw;
		mx_s1        <= mag_x;
		my_s1        <= mag_y;
		nx_s1        <= neg_x;
		ny_s1        <= neg_y;
		col_s1.blue  <= pixel.blue_in;
		col_s1.green <= pixel.green_in;
		col_s1.red   <= pixel.red_in;
	end

	// Stage 2: depth times reciprocal scale, offsets times reciprocal focals.
	always_ff @(posedge clk) begin
		zp_s2  <= PROD_W'(depth_s1) * PROD_W'(recip_dscale_q);
		mx_s2  <= PROD_W'(mx_s1) * PROD_W'(recip_fx_q);
		my_s2  <= PROD_W'(my_s1) * PROD_W'(recip_fy_q);
		nx_s2  <= nx_s1;
		ny_s2  <= ny_s1;
		col_s2 <= col_s1;
	end

	// Stage 3: round the depth product to Q16.16.
	logic [PROD_W-1:0] zp_round;
	assign zp_round = zp_s2 + PROD_W'(1 << (Z_SHIFT - 1));

	always_ff @(posedge clk) begin
		z_s3   <= zp_round[Z_SHIFT +: dpb_pkg::POINT_W];
		mx_s3  <= mx_s2;
		my_s3  <= my_s2;
		nx_s3  <= nx_s2;
		ny_s3  <= ny_s2;
		col_s3 <= col_s2;
	end

	// Stage 4: split the 40x32 products into two 20x32 partial products.
	always_ff @(posedge clk) begin
		xh_s4  <= PART_W'(mx_s3[PROD_W-1:HALF_W]) * PART_W'(z_s3);
		xl_s4  <= PART_W'(mx_s3[HALF_W-1:0]) * PART_W'(z_s3);
		yh_s4  <= PART_W'(my_s3[PROD_W-1:HALF_W]) * PART_W'(z_s3);
		yl_s4  <= PART_W'(my_s3[HALF_W-1:0]) * PART_W'(z_s3);
		z_s4   <= z_s3;
		nx_s4  <= nx_s3;
		ny_s4  <= ny_s3;
		col_s4 <= col_s3;
	end

	// Stage 5: recombine, round half up on the magnitude and drop to Q16.16.
	logic [SUM_W-1:0] sum_x;
	logic [SUM_W-1:0] sum_y;
	assign sum_x = {xh_s4, HALF_W'(0)} + SUM_W'(xl_s4) + (SUM_W'(1) << (Q_SHIFT - 1));
	assign sum_y = {yh_s4, HALF_W'(0)} + SUM_W'(yl_s4) + (SUM_W'(1) << (Q_SHIFT - 1));

	always_ff @(posedge clk) begin
		qx_s5  <= sum_x[SUM_W-1:Q_SHIFT];
		qy_s5  <= sum_y[SUM_W-1:Q_SHIFT];
		z_s5   <= z_s4;
		nx_s5  <= nx_s4;
		ny_s5  <= ny_s4;
		col_s5 <= col_s4;
	end

	// Stage 6: apply the sign and saturate to the signed 32-bit range.
	logic [dpb_pkg::POINT_W-1:0] sat_x;
	logic [dpb_pkg::POINT_W-1:0] sat_y;

	always_comb begin
		if (nx_s5) begin
			sat_x = (qx_s5 >= Q_W'(dpb_pkg::SAT_NEG)) ? dpb_pkg::SAT_NEG :
				(dpb_pkg::POINT_W'(0) - qx_s5[dpb_pkg::POINT_W-1:0]);
		end else begin
			sat_x = (qx_s5 > Q_W'(dpb_pkg::SAT_POS)) ? dpb_pkg::SAT_POS :
				qx_s5[dpb_pkg::POINT_W-1:0];
		end
		if (ny_s5) begin
			sat_y = (qy_s5 >= Q_W'(dpb_pkg::SAT_NEG)) ? dpb_pkg::SAT_NEG :
				(dpb_pkg::POINT_W'(0) - qy_s5[dpb_pkg::POINT_W-1:0]);
		end else begin
			sat_y = (qy_s5 > Q_W'(dpb_pkg::SAT_POS)) ? dpb_pkg::SAT_POS :
				qy_s5[dpb_pkg::POINT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		px_s6  <= sat_x;
		py_s6  <= sat_y;
		z_s6   <= z_s5;
		col_s6 <= col_s5;
	end

	// Result beat, shown for exactly one cycle.
	assign done            = v_s6;
	assign point.point_x   = px_s6;
	assign point.point_y   = py_s6;
	assign point.point_z   = z_s6;
	assign point.blue_out  = col_s6.blue;
	assign point.green_out = col_s6.green;
	assign point.red_out   = col_s6.red;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
`include "depth_pixel_backprojection_defines.svh"

	// Every result traces back to a beat taken at the pipeline entry.
	`DPB_ASSERT_IMPL(a_done_has_source, clk, arst_n, done, $past(start && !busy, 6), "result without a source pixel")
	// A pixel without depth never produces a result.
	`DPB_ASSERT_NEXT(a_zero_depth_dropped, clk, arst_n, start && !busy && pixel.depth_raw == '0, ##5 !done, "zero-depth pixel produced a result")
	// The origin pixel lies on every grid and, given depth, must come out.
	`DPB_ASSERT_IMPL(a_origin_kept, clk, arst_n, start && !busy && pixel.depth_raw != '0 && pixel.pixel_row == '0 && pixel.pixel_col == '0, ##6 done, "origin pixel lost")
	// A point at zero depth lies on the optical axis.
	`DPB_ASSERT_IMPL(a_zero_z_on_axis, clk, arst_n, done && point.point_z == '0, point.point_x == '0 && point.point_y == '0, "off-axis point at zero depth")

endmodule

`default_nettype wire

// ===== dv/depth_pixel_backprojection_test.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection: self-checking testbench
// Sends pixel beats and programs the calibration registers over APB. Every
// point that comes back is checked, field by field, against a bit-exact
// fixed-point model of the pinhole back-projection kept in this bench.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_test;

	timeunit 1ns;
	timeprecision 1ps;

	import dpb_pkg::*;

	localparam int unsigned STRIDE        = 2;
	localparam int unsigned CLK_PERIOD    = 4;
	localparam int unsigned RESET_CYCLES  = 5;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned TAIL_CYCLES   = 16;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned PHASES        = 5;
	localparam int unsigned POINTS_PER_PHASE = 80;
	localparam int unsigned EDGE_COORD    = 4096 - STRIDE;

	// Addresses past the register map; writes there must change nothing.
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

	// How a directed row is handled, and what the random phases program.
	typedef enum logic [1:0] {ROW_PREDICT, ROW_SKIPPED, ROW_KNOWN, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {CAL_REALISTIC, CAL_RANDOM, CAL_EXTREME, CAL_RESET} cal_style_t;

	typedef struct {
		row_kind_t  kind;
		pixel_t     pix;
		point_t     known;
		logic [2:0] reg_idx;
		logic [31:0] reg_val;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pixel_t pixel_beat = '0;
	logic done;
	point_t point_beat;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Calibration as the block should currently hold it.
	logic [CENTER_W-1:0] cal_center_x     = RST_CENTER_X;
	logic [CENTER_W-1:0] cal_center_y     = RST_CENTER_Y;
	logic [RECIP_W-1:0]  cal_recip_fx     = RST_RECIP_FX;
	logic [RECIP_W-1:0]  cal_recip_fy     = RST_RECIP_FY;
	logic [RECIP_W-1:0]  cal_recip_dscale = RST_RECIP_DSCALE;

	point_t expected_points[$];
	point_t want;
	int unsigned mismatches = 0;
	int unsigned pixels_sent = 0;
	int unsigned points_predicted = 0;
	int unsigned points_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned idle_cycles = 0;

	depth_pixel_backprojection #(
		.SUBSAMPLE_STRIDE(STRIDE)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel_beat),
		.done   (done),
		.point  (point_beat),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("MISMATCH at %0t ns: %s got %h, expected %h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// Signed Q16.16 lateral coordinate: rounded half away from zero, saturated.
	function automatic logic [31:0] lateral_coord(input logic [11:0] pix,
			input logic [15:0] centre, input logic [23:0] recip, input logic [31:0] z);
		logic [16:0] p16;
		logic [16:0] c17;
		logic [16:0] mag;
		logic neg;
		logic [127:0] prod;
		logic [127:0] q;
		p16 = {1'b0, pix, 4'b0000};
		c17 = {1'b0, centre};
		neg = p16 < c17;
		mag = neg ? c17 - p16 : p16 - c17;
		prod = 128'(mag) * 128'(recip) * 128'(z);
		q = (prod + (128'd1 << 27)) >> 28;
		if (neg) begin
			if (q >= 128'h8000_0000)
				return SAT_NEG;
			return -q[31:0];
		end
		if (q > 128'h7FFF_FFFF)
			return SAT_POS;
		return q[31:0];
	endfunction

	// Back-projects one pixel; returns 0 for a pixel off the grid or without depth.
	function automatic bit project_pixel(input pixel_t p, output point_t pt);
		logic [63:0] depth_prod;
		pt = '0;
		if (32'(p.pixel_row) % STRIDE != 0 || 32'(p.pixel_col) % STRIDE != 0 ||
				p.depth_raw == '0)
			return 1'b0;
		depth_prod = 64'(p.depth_raw) * 64'(cal_recip_dscale) + 64'd128;
		pt.point_z = depth_prod[39:8];
		pt.point_x = lateral_coord(p.pixel_col, cal_center_x, cal_recip_fx, pt.point_z);
		pt.point_y = lateral_coord(p.pixel_row, cal_center_y, cal_recip_fy, pt.point_z);
		pt.blue_out = p.blue_in;
		pt.green_out = p.green_in;
		pt.red_out = p.red_in;
		return 1'b1;
	endfunction

	function automatic void apply_register(input logic [2:0] idx, input logic [31:0] value);
		case (idx)
			REG_CENTER_X:     cal_center_x = value[CENTER_W-1:0];
			REG_CENTER_Y:     cal_center_y = value[CENTER_W-1:0];
			REG_RECIP_FX:     cal_recip_fx = value[RECIP_W-1:0];
			REG_RECIP_FY:     cal_recip_fy = value[RECIP_W-1:0];
			REG_RECIP_DSCALE: cal_recip_dscale = value[RECIP_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] register_value(input logic [2:0] idx);
		case (idx)
			REG_CENTER_X:     return {16'd0, cal_center_x};
			REG_CENTER_Y:     return {16'd0, cal_center_y};
			REG_RECIP_FX:     return {8'd0, cal_recip_fx};
			REG_RECIP_FY:     return {8'd0, cal_recip_fy};
			default:          return {8'd0, cal_recip_dscale};
		endcase
	endfunction

	function automatic directed_row_t pixel_entry(input row_kind_t kind, input int unsigned row,
			input int unsigned col, input int unsigned depth, input logic [23:0] bgr,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		directed_row_t e;
		e.kind = kind;
		e.reg_idx = REG_CENTER_X;
		e.reg_val = '0;
		e.pix.pixel_row = COORD_W'(row);
		e.pix.pixel_col = COORD_W'(col);
		e.pix.depth_raw = DEPTH_W'(depth);
		{e.pix.blue_in, e.pix.green_in, e.pix.red_in} = bgr;
		e.known.point_x = x;
		e.known.point_y = y;
		e.known.point_z = z;
		{e.known.blue_out, e.known.green_out, e.known.red_out} = bgr;
		return e;
	endfunction

	function automatic directed_row_t reg_entry(input logic [2:0] idx, input logic [31:0] value);
		directed_row_t e;
		e.kind = ROW_WRITE;
		e.pix = '0;
		e.known = '0;
		e.reg_idx = idx;
		e.reg_val = value;
		return e;
	endfunction

	// Mostly grid pixels with depth, some at the extremes, the rest random or without depth.
	function automatic pixel_t random_pixel();
		pixel_t p;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		p.pixel_row = COORD_W'($urandom_range(0, 4095));
		p.pixel_col = COORD_W'($urandom_range(0, 4095));
		p.depth_raw = DEPTH_W'($urandom_range(0, 65535));
		p.blue_in = COLOR_W'($urandom_range(0, 255));
		p.green_in = COLOR_W'($urandom_range(0, 255));
		p.red_in = COLOR_W'($urandom_range(0, 255));
		if (pick < 80) begin
			p.pixel_row = p.pixel_row - COORD_W'(32'(p.pixel_row) % STRIDE);
			p.pixel_col = p.pixel_col - COORD_W'(32'(p.pixel_col) % STRIDE);
			if (p.depth_raw == '0)
				p.depth_raw = 16'd1;
		end
		if (pick < 10) begin
			p.pixel_row = $urandom_range(0, 1) ? COORD_W'(EDGE_COORD) : COORD_W'(0);
			p.pixel_col = $urandom_range(0, 1) ? COORD_W'(EDGE_COORD) : COORD_W'(0);
			p.depth_raw = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
		end else if (pick >= 90) begin
			p.depth_raw = '0;
		end
		return p;
	endfunction

	// One pixel beat; start is left high so a following beat can go back to back.
	task automatic send_pixel(input directed_row_t entry);
		point_t pt;
		pixel_beat <= entry.pix;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		pixels_sent++;
		case (entry.kind)
			ROW_KNOWN: begin
				expected_points = {expected_points, entry.known};
				points_predicted++;
			end
			ROW_PREDICT: begin
				if (project_pixel(entry.pix, pt)) begin
					expected_points = {expected_points, pt};
					points_predicted++;
				end
			end
			default: ;
		endcase
	endtask

	task automatic idle_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Skipped pixels leave no trace in the queue, so allow the pipeline to empty too.
	task automatic drain_points();
		start <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read of the same address.
	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		apply_register(idx, value);
		reg_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx <= REG_RECIP_DSCALE && readback !== register_value(idx))
			report_mismatch($sformatf("register %0d read-back", idx), readback,
				register_value(idx));
	endtask

	// Programs every register, with junk in the bits above each field.
	task automatic program_calibration(input cal_style_t style);
		logic [2:0] idx;
		logic [31:0] field;
		logic [31:0] field_max;
		bit is_center;
		for (int k = 0; k <= int'(REG_RECIP_DSCALE); k++) begin
			idx = 3'(k);
			is_center = (idx == REG_CENTER_X || idx == REG_CENTER_Y);
			field_max = is_center ? 32'h0000_FFFF : 32'h00FF_FFFF;
			case (style)
				CAL_REALISTIC: begin
					if (is_center)
						field = $urandom_range(0, 65535);
					else if (idx == REG_RECIP_DSCALE)
						field = $urandom_range(1600, 17000);
					else
						field = $urandom_range(4000, 90000);
				end
				CAL_RANDOM:  field = $urandom & field_max;
				CAL_EXTREME: field = $urandom_range(0, 1) ? field_max : 32'd0;
				default: begin
					case (idx)
						REG_CENTER_X: field = 32'(RST_CENTER_X);
						REG_CENTER_Y: field = 32'(RST_CENTER_Y);
						REG_RECIP_FX: field = 32'(RST_RECIP_FX);
						REG_RECIP_FY: field = 32'(RST_RECIP_FY);
						default:      field = 32'(RST_RECIP_DSCALE);
					endcase
				end
			endcase
			write_register(idx, field | ($urandom & ~field_max));
		end
		if ($urandom_range(0, 1))
			write_register(3'($urandom_range(int'(REG_SPARE_FIRST), int'(REG_SPARE_LAST))),
				$urandom);
	endtask

	// Result checker: every beat with done is matched to the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			points_seen++;
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected point, point_z", point_beat.point_z, 32'd0);
			end else begin
				want = expected_points.pop_front();
				if (point_beat.point_x !== want.point_x)
					report_mismatch("point_x", point_beat.point_x, want.point_x);
				if (point_beat.point_y !== want.point_y)
					report_mismatch("point_y", point_beat.point_y, want.point_y);
				if (point_beat.point_z !== want.point_z)
					report_mismatch("point_z", point_beat.point_z, want.point_z);
				if (point_beat.blue_out !== want.blue_out)
					report_mismatch("blue_out", point_beat.blue_out, want.blue_out);
				if (point_beat.green_out !== want.green_out)
					report_mismatch("green_out", point_beat.green_out, want.green_out);
				if (point_beat.red_out !== want.red_out)
					report_mismatch("red_out", point_beat.red_out, want.red_out);
			end
		end
	end

	// Watchdog: too long without a pixel beat, a point or a register access.
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Watchdog expired with %0d points outstanding",
					expected_points.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		directed_row_t rows[$];
		directed_row_t entry;
		int unsigned phase_mark;
		int unsigned beats_in_stretch;
		bit gaps_on;
		cal_style_t style;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: principal point, skipped pixels and coordinate extremes
		// with the reset calibration.
		rows = {rows, pixel_entry(ROW_KNOWN, 240, 320, 1000, 24'h123456,
			0, 0, 32'h0000_FFFF)};
		rows = {rows, pixel_entry(ROW_SKIPPED, 0, 0, 0, 24'hFFFFFF, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_SKIPPED, 1, 0, 500, 24'h00FF00, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_SKIPPED, 0, 4095, 500, 24'hFF0000, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_SKIPPED, 4095, 4095, 65535, 24'h0000FF, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_PREDICT, 0, 0, 65535, 24'h000000, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_PREDICT, EDGE_COORD, EDGE_COORD, 65535, 24'hFFFFFF,
			0, 0, 0)};
		rows = {rows, pixel_entry(ROW_PREDICT, EDGE_COORD, 0, 1, 24'hA5A5A5, 0, 0, 0)};
		// Full-scale reciprocals with the principal point at opposite corners:
		// both lateral coordinates saturate.
		rows = {rows, reg_entry(REG_CENTER_X, 32'd0)};
		rows = {rows, reg_entry(REG_CENTER_Y, 32'h0000_FFFF)};
		rows = {rows, reg_entry(REG_RECIP_FX, 32'h00FF_FFFF)};
		rows = {rows, reg_entry(REG_RECIP_FY, 32'h00FF_FFFF)};
		rows = {rows, reg_entry(REG_RECIP_DSCALE, 32'h00FF_FFFF)};
		rows = {rows, pixel_entry(ROW_KNOWN, 0, EDGE_COORD, 65535, 24'h5A5A5A,
			SAT_POS, SAT_NEG, 32'hFFFE_FF00)};
		rows = {rows, pixel_entry(ROW_PREDICT, EDGE_COORD, 0, 65535, 24'h0F0F0F, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_PREDICT, 2, 2, 1, 24'hF0F0F0, 0, 0, 0)};
		// A zero depth reciprocal still gives a point, at the origin.
		rows = {rows, reg_entry(REG_RECIP_DSCALE, 32'd0)};
		rows = {rows, pixel_entry(ROW_KNOWN, 100, 100, 65535, 24'h010203, 0, 0, 0)};
		// Writes beyond the register map must leave the calibration alone.
		rows = {rows, reg_entry(REG_SPARE_FIRST, 32'hFFFF_FFFF)};
		rows = {rows, reg_entry(REG_SPARE_LAST, 32'h0000_1234)};
		rows = {rows, pixel_entry(ROW_KNOWN, 100, 100, 1234, 24'h040506, 0, 0, 0)};
		// Excess upper bits are dropped, which brings back the reset calibration.
		rows = {rows, reg_entry(REG_CENTER_X, 32'hFFFF_1400)};
		rows = {rows, reg_entry(REG_CENTER_Y, 32'hABCD_0F00)};
		rows = {rows, reg_entry(REG_RECIP_FX, 32'hFF00_7CD5)};
		rows = {rows, reg_entry(REG_RECIP_FY, 32'h1200_7CD5)};
		rows = {rows, reg_entry(REG_RECIP_DSCALE, 32'hFF00_4189)};
		rows = {rows, pixel_entry(ROW_KNOWN, 240, 320, 1000, 24'h778899,
			0, 0, 32'h0000_FFFF)};
		rows = {rows, pixel_entry(ROW_PREDICT, 0, 0, 1, 24'h102030, 0, 0, 0)};
		rows = {rows, pixel_entry(ROW_PREDICT, 480, 640, 65535, 24'h405060, 0, 0, 0)};

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				drain_points();
				write_register(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				send_pixel(rows[i]);
				if ($urandom_range(0, 3) == 0)
					idle_sender($urandom_range(1, 13));
			end
		end

		// Random phases, each under a fresh calibration; the last runs without gaps.
		entry = reg_entry(REG_CENTER_X, 32'd0);
		entry.kind = ROW_PREDICT;
		gaps_on = 1'b1;
		beats_in_stretch = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1:       style = CAL_RANDOM;
				2:       style = CAL_EXTREME;
				4:       style = CAL_RESET;
				default: style = CAL_REALISTIC;
			endcase
			drain_points();
			program_calibration(style);
			phase_mark = points_predicted;
			while (points_predicted - phase_mark < POINTS_PER_PHASE) begin
				entry.pix = random_pixel();
				send_pixel(entry);
				if (phase == 1 && points_predicted - phase_mark == POINTS_PER_PHASE / 2)
					drain_points();
				else if (phase < PHASES - 1 && gaps_on && $urandom_range(0, 5) == 0)
					idle_sender($urandom_range(1, 13));
				beats_in_stretch++;
				if (beats_in_stretch == 32) begin
					beats_in_stretch = 0;
					gaps_on = $urandom_range(0, 9) < 7;
				end
			end
		end

		start <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d pixel beats (%0d points, %0d skipped) over %0d random phases",
			pixels_sent, points_seen, pixels_sent - points_predicted, PHASES);
		$display("Made %0d register writes with read-back; %0d mismatches", reg_writes,
			mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dpb_pkg.sv
rtl/core/depth_pixel_backprojection.sv
dv/depth_pixel_backprojection_test.sv
